FILE: src/time_sync_node_slot_keeper_unit_macros.svh
// ----------------------------------------------------------------------------
// Slot keeper assertion macros
// Shared concurrent assertion wrappers. Each clocks on clk_i and is disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIME_SYNC_NODE_SLOT_KEEPER_UNIT_MACROS_SVH
`define TIME_SYNC_NODE_SLOT_KEEPER_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TSNSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication that is checked in the same cycle.
`define TSNSK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define TSNSK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tsnsk_pkg.sv
// ----------------------------------------------------------------------------
// Slot keeper package
// Types, constants and codes shared by the slot keeper modules.
// ----------------------------------------------------------------------------
package tsnsk_pkg;

  localparam int unsigned TimeW   = 63;
  localparam int unsigned OffsW   = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned AddrW   = 5;

  // The modulo unit retires this many quotient bits per cycle.
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivIters        = OffsW / DivBitsPerCycle;
  localparam int unsigned DivCntW         = $clog2(DivIters);

  localparam logic [WordW-1:0] TimeoutReset = 32'd5000000;

  typedef enum logic [2:0] {
    REG_SLOT_ENABLE   = 3'd0,
    REG_SLOT_PERIOD   = 3'd1,
    REG_SLOT_START    = 3'd2,
    REG_SLOT_WIDTH    = 3'd3,
    REG_VALID_TIMEOUT = 3'd4
  } tsnsk_reg_e;

  typedef enum logic [1:0] {
    PKT_START     = 2'd0,
    PKT_APPLY     = 2'd1,
    PKT_HEARTBEAT = 2'd2,
    PKT_OTHER     = 2'd3
  } tsnsk_pkt_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACKET,
    ST_EVAL,
    ST_DIVIDE,
    ST_WRITE
  } tsnsk_state_e;

  typedef struct packed {
    logic [TimeW-1:0]        now_local_us;
    logic                    packet_present;
    logic                    packet_complete;
    logic [1:0]              packet_type;
    logic [WordW-1:0]        packet_seq;
    logic signed [OffsW-1:0] packet_offset_us;
  } tsnsk_req_t;

  typedef struct packed {
    logic                    packet_accepted;
    logic signed [OffsW-1:0] global_time_us;
    logic                    in_slot;
    logic                    sync_valid;
    logic                    is_synced;
    logic [WordW-1:0]        applied_count;
  } tsnsk_rsp_t;

  // Command to the modulo unit.
  typedef struct packed {
    logic             start;
    logic [OffsW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } tsnsk_div_req_t;

  // Status from the modulo unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] remainder;
  } tsnsk_div_rsp_t;

endpackage

FILE: src/tsnsk_mod_unit.sv
// ----------------------------------------------------------------------------
// Slot keeper modulo unit
// Iterative restoring 64-by-32 remainder, DivBitsPerCycle quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "time_sync_node_slot_keeper_unit_macros.svh"

module tsnsk_mod_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tsnsk_pkg::tsnsk_div_req_t div_req_i,
  output tsnsk_pkg::tsnsk_div_rsp_t div_rsp_o
);
  import tsnsk_pkg::*;

  localparam logic [DivCntW-1:0] LastIter = DivCntW'(DivIters - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [OffsW-1:0]   dvd_q, dvd_d;
  logic [WordW-1:0]   dsr_q, dsr_d;
  logic [WordW-1:0]   rem_q, rem_d;
  logic [WordW-1:0]   rem_step;

  // Restoring steps of each iteration: shift in a dividend bit, subtract if it fits.
  always_comb begin
    logic [WordW:0] trial;
    rem_step = rem_q;
    for (int k = 0; k < DivBitsPerCycle; k++) begin
      trial = {rem_step, dvd_q[OffsW-1-k]};
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_step = trial[WordW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (div_req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = div_req_i.dividend;
      dsr_d  = div_req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_step;
      dvd_d = dvd_q << DivBitsPerCycle;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastIter) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign div_rsp_o.busy      = busy_q;
  assign div_rsp_o.done      = done_q;
  assign div_rsp_o.remainder = rem_q;

  // A finished remainder is always below the divisor.
  `TSNSK_ASSERT_IMP(a_rem_below_divisor, done_q, rem_q < dsr_q, "remainder not below divisor")

endmodule

FILE: src/time_sync_node_slot_keeper_unit.sv
// ----------------------------------------------------------------------------
// Time sync node slot keeper
// Node side of a two-way clock sync scheme with a TDMA transmit slot.
// ----------------------------------------------------------------------------
// Each request carries the local microsecond time and optionally one received
// sync packet, and yields exactly one result. A request is handled in steps:
// the packet updates the sync state, then global time and validity are formed,
// then, when slot gating is active, the slot phase is found by a shared
// iterative modulo unit that retires two quotient bits per cycle over 32
// passes. A request that needs no slot phase skips that unit and goes from
// the eval step straight to the write step. The
// input side is stalled while a request is in work and accepts the next one
// as soon as the result has moved into the output register, even if that
// result is still stalled downstream. Configuration registers sit at byte
// addresses 0, 4, 8, 12 and 16 and must only be written while no request is
// in work.
`include "time_sync_node_slot_keeper_unit_macros.svh"

module time_sync_node_slot_keeper_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tsnsk_pkg::tsnsk_req_t                 in_req_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tsnsk_pkg::tsnsk_rsp_t                 out_rsp_o,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsnsk_pkg::AddrW-1:0]           paddr,
  input  logic [tsnsk_pkg::WordW-1:0]           pwdata,
  output logic [tsnsk_pkg::WordW-1:0]           prdata,
  output logic                                  pready
);
  import tsnsk_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic             slot_en_q;
  logic [WordW-1:0] period_q;
  logic [WordW-1:0] start_q;
  logic [WordW-1:0] width_q;
  logic [WordW-1:0] timeout_q;
  logic             cfg_wr;
  tsnsk_reg_e       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tsnsk_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_en_q <= 1'b0;
      period_q  <= '0;
      start_q   <= '0;
      width_q   <= '0;
      timeout_q <= TimeoutReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SLOT_ENABLE:   slot_en_q <= pwdata[0];
        REG_SLOT_PERIOD:   period_q  <= pwdata;
        REG_SLOT_START:    start_q   <= pwdata;
        REG_SLOT_WIDTH:    width_q   <= pwdata;
        REG_VALID_TIMEOUT: timeout_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Reads of addresses beyond the register list return zero.
  always_comb begin
    unique case (cfg_idx)
      REG_SLOT_ENABLE:   prdata = {{(WordW-1){1'b0}}, slot_en_q};
      REG_SLOT_PERIOD:   prdata = period_q;
      REG_SLOT_START:    prdata = start_q;
      REG_SLOT_WIDTH:    prdata = width_q;
      REG_VALID_TIMEOUT: prdata = timeout_q;
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  tsnsk_state_e   state_q, state_d;
  tsnsk_div_req_t div_req;
  tsnsk_div_rsp_t div_rsp;
  logic           in_take;
  logic           out_free;
  logic           gate_on;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PACKET;
      ST_PACKET: state_d = ST_EVAL;
      ST_EVAL:   state_d = gate_on ? ST_DIVIDE : ST_WRITE;
      ST_DIVIDE: if (div_rsp.done) state_d = ST_WRITE;
      ST_WRITE:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sync state and per-request datapath.
  // --------------------------------------------------------------------------
  tsnsk_req_t       req_q, req_d;
  logic [OffsW-1:0] offset_q, offset_d;
  logic [WordW-1:0] last_seq_q, last_seq_d;
  logic [WordW-1:0] count_q, count_d;
  logic             synced_q, synced_d;
  logic [TimeW-1:0] refresh_q, refresh_d;
  logic             acc_q, acc_d;
  logic [OffsW-1:0] global_q, global_d;
  logic             valid_q, valid_d;
  logic             slot_q, slot_d;
  tsnsk_rsp_t       out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             pkt_ok;
  logic [OffsW-1:0] elapsed;
  logic             time_back;
  logic             fresh;
  logic [WordW:0]   slot_end;
  logic             phase_hit;

  assign pkt_ok  = req_q.packet_present && req_q.packet_complete;
  // Gating is active only when enabled, synced and the period is nonzero.
  assign gate_on = slot_en_q && synced_q && (period_q != '0);

  // The top bit of the extended difference is the borrow, set when time ran
  // backwards past the last refresh.
  assign elapsed   = {1'b0, req_q.now_local_us} - {1'b0, refresh_q};
  assign time_back = elapsed[OffsW-1];
  assign fresh     = (elapsed[TimeW-1:WordW] == '0) && (elapsed[WordW-1:0] < timeout_q);

  assign slot_end  = {1'b0, start_q} + {1'b0, width_q};
  assign phase_hit = (div_rsp.remainder >= start_q) &&
                     ({1'b0, div_rsp.remainder} < slot_end);

  assign div_req.start    = (state_q == ST_EVAL) && gate_on;
  assign div_req.dividend = global_d;
  assign div_req.divisor  = period_q;

  always_comb begin
    req_d       = req_q;
    offset_d    = offset_q;
    last_seq_d  = last_seq_q;
    count_d     = count_q;
    synced_d    = synced_q;
    refresh_d   = refresh_q;
    acc_d       = acc_q;
    global_d    = global_q;
    valid_d     = valid_q;
    slot_d      = slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_take) begin
      req_d = in_req_i;
    end

    unique case (state_q)
      ST_PACKET: begin
        acc_d = 1'b0;
        if (pkt_ok) begin
          unique case (tsnsk_pkt_e'(req_q.packet_type))
            PKT_START: acc_d = 1'b1;
            PKT_APPLY: begin
              // Only a strictly newer sequence number is applied.
              if (req_q.packet_seq > last_seq_q) begin
                offset_d   = req_q.packet_offset_us;
                last_seq_d = req_q.packet_seq;
                count_d    = count_q + 1'b1;
                synced_d   = 1'b1;
                refresh_d  = req_q.now_local_us;
                acc_d      = 1'b1;
              end
            end
            PKT_HEARTBEAT: begin
              refresh_d = req_q.now_local_us;
              acc_d     = 1'b1;
            end
            PKT_OTHER: acc_d = 1'b0;
            default:   acc_d = 1'b0;
          endcase
        end
      end
      ST_EVAL: begin
        global_d = synced_q ? ({1'b0, req_q.now_local_us} + offset_q)
                            : {1'b0, req_q.now_local_us};
        valid_d  = synced_q && (time_back || fresh);
        slot_d   = 1'b1;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          slot_d = phase_hit;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          out_d.packet_accepted = acc_q;
          out_d.global_time_us  = $signed(global_q);
          out_d.in_slot         = slot_q;
          out_d.sync_valid      = valid_q;
          out_d.is_synced       = synced_q;
          out_d.applied_count   = count_q;
          out_valid_d           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      last_seq_q  <= '0;
      count_q     <= '0;
      synced_q    <= 1'b0;
      refresh_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      last_seq_q  <= last_seq_d;
      count_q     <= count_d;
      synced_q    <= synced_d;
      refresh_q   <= refresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    acc_q    <= acc_d;
    global_q <= global_d;
    valid_q  <= valid_d;
    slot_q   <= slot_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // --------------------------------------------------------------------------
  // Shared modulo unit for the slot phase.
  // --------------------------------------------------------------------------
  tsnsk_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Once an offset is applied the node stays synced until reset.
  `TSNSK_ASSERT(a_sync_sticky, !$fell(synced_q), "synced flag dropped")
  // The apply count only moves together with a synced node.
  `TSNSK_ASSERT_IMP(a_count_needs_sync, count_q != $past(count_q), synced_q, "count moved while unsynced")
  // A result outside its slot needs gating to have been active.
  `TSNSK_ASSERT_IMP(a_slot_gating, out_valid_q && !out_q.in_slot, slot_en_q && out_q.is_synced, "in_slot low without gating")
  // The modulo unit only runs while the sequencer waits for it.
  `TSNSK_ASSERT_IMP(a_div_in_divide, div_rsp.busy || div_rsp.done, state_q == ST_DIVIDE, "modulo unit active outside divide step")
  // A request is followed by its packet step.
  `TSNSK_ASSERT_NXT(a_take_to_packet, in_take, state_q == ST_PACKET, "accepted request not handled")

endmodule
